### hw/rtl/vrbd_pkg.sv
// ----------------------------------------------------------------------------
// vrbd_pkg
// Types and constants shared by the vertex report bank deframer.
// ----------------------------------------------------------------------------
package vrbd_pkg;

    localparam int WORD_W     = 32;
    localparam int ID_W       = 16;
    localparam int NVERT_W    = 16;
    localparam int VERSION_W  = 8;
    localparam int FIELD_W    = 4;
    localparam int WLEFT_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FIELD_W-1:0] SHORT_VERTEX_WORDS = 4'd5;
    localparam logic [FIELD_W-1:0] LONG_VERTEX_WORDS  = 4'd11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT1_ID = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT1_EN = 2'd3;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic [WORD_W-1:0]    bank_word;
        logic                 first_word;
        logic                 last_word;
        logic [VERSION_W-1:0] bank_version;
    } t_in_item;

    typedef struct packed {
        logic               data_valid;
        logic               slot_opened;
        logic               out_slot;
        logic [NVERT_W-1:0] vertex_index;
        logic [FIELD_W-1:0] field_index;
        logic [WORD_W-1:0]  field_value;
        logic               bank_done;
        logic               count_error;
        logic               size_error;
        logic               duplicate_seen;
    } t_out_item;

endpackage

### hw/rtl/vertex_report_bank_deframer_top.sv
// ----------------------------------------------------------------------------
// vertex_report_bank_deframer_top
// Splits a vertex report bank into tagged vertex words for two output slots.
// ----------------------------------------------------------------------------
// Bank words enter one item per cycle, unless a stalled result holds them
// back, and load the result register. Every word is decoded by a single
// pass of counter and compare logic that updates the frame state and loads
// the result register in the same cycle; the result register is the only
// thing that can hold the input back, and only while its item is stalled.
// A first_word item (the selection count) always restarts decoding. Each
// selection header carries a vertex count in bits 15..0 and a selection id
// in bits 31..16, then count*5 words (version 0) or count*11 words. A header
// whose id matches an enabled slot register (slot 0 first) opens that slot
// and yields a slot_opened item; its payload words come out tagged with
// vertex and field index. Unmatched selections and repeats of an opened slot
// produce nothing. The last word yields one bank_done item with the count,
// size and duplicate flags unless decoding waits for a first_word item.
// Words that produce nothing are simply consumed. The user must write slot
// registers via i_cfg_* only while the block is idle; it is not enforced.
module vertex_report_bank_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  vrbd_pkg::t_in_item            i_in_item,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output vrbd_pkg::t_out_item           o_out_item,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [vrbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vrbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vrbd_pkg::*;

    // configuration registers
    logic [ID_W-1:0] r_slot0_id, r_slot1_id;
    logic            r_slot0_en, r_slot1_en;

    // frame state
    t_phase             r_phase, n_phase;
    logic [WORD_W-1:0]  r_sel_left, n_sel_left;
    logic [WLEFT_W-1:0] r_words_left, n_words_left;
    logic               r_eleven, n_eleven;
    logic               r_decoded, n_decoded;
    logic               r_cur_slot, n_cur_slot;
    logic [NVERT_W-1:0] r_vertex, n_vertex;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [1:0]         r_opened, n_opened;
    logic               r_dup, n_dup;

    // result register
    logic      r_out_valid, n_emit;
    t_out_item r_out_item, n_result;

    logic in_accept;

    // header decode
    logic [NVERT_W-1:0] hdr_nvert;
    logic [ID_W-1:0]    hdr_id;
    logic               hit0, hit1, hit_any, hit_slot, hit_dup;
    logic [WLEFT_W-1:0] hdr_words;
    logic [FIELD_W-1:0] per_vertex;
    logic [FIELD_W-1:0] field_inc;
    logic               vertex_wrap;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign hdr_nvert = i_in_item.bank_word[NVERT_W-1:0];
    assign hdr_id    = i_in_item.bank_word[WORD_W-1 -: ID_W];
    assign hit0      = r_slot0_en && (hdr_id == r_slot0_id);
    assign hit1      = r_slot1_en && (hdr_id == r_slot1_id);
    assign hit_any   = hit0 || hit1;
    assign hit_slot  = !hit0;                 // slot 0 wins when both match
    assign hit_dup   = r_opened[hit_slot];

    // count*5 = 4n+n, count*11 = 8n+2n+n; fits in 20 bits
    always_comb begin
        hdr_words = {2'b00, hdr_nvert, 2'b00} + {4'b0000, hdr_nvert};
        if (r_eleven) begin
            hdr_words = {1'b0, hdr_nvert, 3'b000} + {3'b000, hdr_nvert, 1'b0}
                      + {4'b0000, hdr_nvert};
        end
    end

    assign per_vertex  = r_eleven ? LONG_VERTEX_WORDS : SHORT_VERTEX_WORDS;
    assign field_inc   = r_field + 4'd1;
    assign vertex_wrap = (field_inc >= per_vertex);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_sel_left   = r_sel_left;
        n_words_left = r_words_left;
        n_eleven     = r_eleven;
        n_decoded    = r_decoded;
        n_cur_slot   = r_cur_slot;
        n_vertex     = r_vertex;
        n_field      = r_field;
        n_opened     = r_opened;
        n_dup        = r_dup;
        if (i_in_item.first_word) begin
            n_sel_left   = i_in_item.bank_word;
            n_eleven     = (i_in_item.bank_version != '0);
            n_words_left = '0;
            n_decoded    = 1'b0;
            n_cur_slot   = 1'b0;
            n_vertex     = '0;
            n_field      = '0;
            n_opened     = '0;
            n_dup        = 1'b0;
            n_phase      = i_in_item.last_word ? PH_WAIT : PH_HEADER;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_sel_left   = r_sel_left - 1'b1;
                    n_words_left = hdr_words;
                    n_vertex     = '0;
                    n_field      = '0;
                    n_decoded    = 1'b0;
                    n_cur_slot   = 1'b0;
                    if (hit_any) begin
                        if (hit_dup) begin
                            n_dup = 1'b1;
                        end else begin
                            n_opened[hit_slot] = 1'b1;
                            n_decoded          = 1'b1;
                            n_cur_slot         = hit_slot;
                        end
                    end
                    if (hdr_words != '0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_field = field_inc;
                    if (vertex_wrap) begin
                        n_field  = '0;
                        n_vertex = r_vertex + 1'b1;
                    end
                    n_words_left = r_words_left - 1'b1;
                    if (n_words_left == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: ;                    // waiting: word ignored
            endcase
            if (i_in_item.last_word && r_phase != PH_WAIT) begin
                n_phase = PH_WAIT;
            end
        end
    end

    // result for the word being accepted
    always_comb begin
        n_emit   = 1'b0;
        n_result = '0;
        if (i_in_item.first_word) begin
            if (i_in_item.last_word) begin
                n_emit               = 1'b1;
                n_result.bank_done   = 1'b1;
                n_result.count_error = (i_in_item.bank_word != '0);
                n_result.size_error  = 1'b1;
            end
        end else if (r_phase != PH_WAIT) begin
            if (r_phase == PH_HEADER) begin
                if (hit_any && !hit_dup) begin
                    n_emit               = 1'b1;
                    n_result.slot_opened = 1'b1;
                    n_result.out_slot    = hit_slot;
                end
            end else if (r_decoded) begin
                n_emit                = 1'b1;
                n_result.data_valid   = 1'b1;
                n_result.out_slot     = r_cur_slot;
                n_result.vertex_index = r_vertex;
                n_result.field_index  = r_field;
                n_result.field_value  = i_in_item.bank_word;
            end
            if (i_in_item.last_word) begin
                n_emit                  = 1'b1;
                n_result.bank_done      = 1'b1;
                n_result.count_error    = (n_sel_left != '0);
                n_result.size_error     = (n_words_left != '0);
                n_result.duplicate_seen = n_dup;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot0_id <= '0;
            r_slot0_en <= 1'b0;
            r_slot1_id <= '0;
            r_slot1_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SLOT0_ID: r_slot0_id <= i_cfg_data[ID_W-1:0];
                REG_SLOT0_EN: r_slot0_en <= i_cfg_data[0];
                REG_SLOT1_ID: r_slot1_id <= i_cfg_data[ID_W-1:0];
                REG_SLOT1_EN: r_slot1_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_sel_left   <= '0;
            r_words_left <= '0;
            r_eleven     <= 1'b0;
            r_decoded    <= 1'b0;
            r_cur_slot   <= 1'b0;
            r_vertex     <= '0;
            r_field      <= '0;
            r_opened     <= '0;
            r_dup        <= 1'b0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_sel_left   <= n_sel_left;
            r_words_left <= n_words_left;
            r_eleven     <= n_eleven;
            r_decoded    <= n_decoded;
            r_cur_slot   <= n_cur_slot;
            r_vertex     <= n_vertex;
            r_field      <= n_field;
            r_opened     <= n_opened;
            r_dup        <= n_dup;
        end
    end

    // result register: loads on every accepted word, drains when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= n_result;
        end
    end

endmodule

### hw/rtl/vrbd_checker.sv
// ----------------------------------------------------------------------------
// vrbd_checker
// Port-level checks for the vertex report bank deframer.
// ----------------------------------------------------------------------------
module vrbd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  vrbd_pkg::t_in_item  i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  vrbd_pkg::t_out_item o_out_item
);
    import vrbd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // input only held back by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending result");

    // error flags only at bank end
    a_err_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.bank_done |->
            !o_out_item.count_error && !o_out_item.size_error
            && !o_out_item.duplicate_seen)
        else $error("error flag outside bank end");

    // a result is a header or a vertex word, never both
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.data_valid && o_out_item.slot_opened))
        else $error("result marked as header and vertex word");

    // count word that is also last reports a size error next cycle
    a_short_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.first_word && i_in_item.last_word
        |=> o_out_valid && o_out_item.bank_done && o_out_item.size_error)
        else $error("single-word bank not reported");

endmodule

bind vertex_report_bank_deframer_top vrbd_checker u_vrbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
